FILE: rtl/core/mft_pkg.sv
// Shared types, constants and codes for the multi-fan tachometer.
`timescale 1ns / 1ps

package mft_pkg;

   localparam int FAN_COUNT_DEF = 6;
   localparam int FAN_IDX_W     = 3;
   localparam int MASK_W        = 6;
   localparam int ACTION_W      = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int TIME_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int RPM_W         = 16;
   localparam int PPR_W         = 4;
   localparam int SCALE_W       = 16;
   localparam int NUM_W         = COUNT_W + SCALE_W;
   localparam int DEN_W         = TIME_W + PPR_W;
   localparam int DSH_W         = DEN_W + RPM_W;
   localparam int STEP_W        = $clog2(RPM_W + 1);

   localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(60000);
   localparam logic [RPM_W-1:0]   RPM_MAX   = '1;

   localparam logic [15:0]      INTERVAL_RESET = 16'd1000;
   localparam logic [15:0]      TIMEOUT_RESET  = 16'd2000;
   localparam logic [PPR_W-1:0] PPR_RESET      = 4'd2;
   localparam logic [15:0]      MIN_RPM_RESET  = 16'd500;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_EDGE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_READ  = 2'd3
   } mft_action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL = 2'd0,
      CSR_TIMEOUT  = 2'd1,
      CSR_PPR      = 2'd2,
      CSR_MIN_RPM  = 2'd3
   } mft_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DEN,
      ST_FAN,
      ST_DIV,
      ST_LIVE,
      ST_LOAD,
      ST_SEND
   } mft_state_type;

   typedef struct packed {
      logic                 req_ready;
      logic                 tick;
      logic                 pulse;
      logic                 clear;
      logic                 den_load;
      logic                 fan_zero;
      logic                 div_start;
      logic                 div_store;
      logic                 live_calc;
      logic                 out_load;
      logic                 rsp_valid;
      logic                 run;
      logic                 last_fan;
      logic [FAN_IDX_W-1:0] fan;
   } mft_ctrl_type;

   typedef struct packed {
      logic           req_valid;
      mft_action_type action;
      logic           due;
      logic           timed_out;
      logic           div_done;
      logic           rsp_taken;
   } mft_stat_type;

endpackage

FILE: rtl/core/mft_if.sv
// Channel interfaces: request, result and register write.
`timescale 1ns / 1ps

interface mft_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [2:0] fan_addr;

   modport source (output valid, output action, output fan_addr, input ready);
   modport sink   (input valid, input action, input fan_addr, output ready);
endinterface

interface mft_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_update;
   logic [2:0]  fan_number;
   logic [15:0] rpm;
   logic        connected;
   logic        stalled;
   logic [5:0]  connection_mask;
   logic        last;

   modport source (output valid, output is_update, output fan_number, output rpm,
                   output connected, output stalled, output connection_mask,
                   output last, input ready);
   modport sink   (input valid, input is_update, input fan_number, input rpm,
                   input connected, input stalled, input connection_mask,
                   input last, output ready);
endinterface

interface mft_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink   (input valid, input reg_index, input data, output ready);
endinterface

FILE: rtl/core/mft_div.sv
// Iterative restoring divider with 16-bit saturated quotient.
`timescale 1ns / 1ps

module mft_div import mft_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [RPM_W-1:0] quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [RPM_W-1:0]  quot_ff, quot_in;
   logic              ge;

   assign ge = DSH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(RPM_W);
         rem_in  = num;
         dsh_in  = {den, RPM_W'(0)};
         quot_in = '0;
      end else if (busy_ff) begin
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(RPM_W)) begin
            if (ge) begin
               quot_in = RPM_MAX;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff[NUM_W-1:0];
            end
            quot_in = {quot_ff[RPM_W-2:0], ge};
            if (step_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/core/mft_seq.sv
// Sequencer stepping the fans through measurement, status and reply phases.
`timescale 1ns / 1ps

module mft_seq import mft_pkg::*; #(
   parameter int FAN_COUNT = FAN_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  mft_stat_type stat,
   output mft_ctrl_type ctrl
);

   localparam logic [FAN_IDX_W-1:0] LAST_FAN = FAN_IDX_W'(FAN_COUNT - 1);

   mft_state_type        state_ff, state_in;
   logic [FAN_IDX_W-1:0] fan_ff, fan_in;
   logic                 run_ff, run_in;
   logic                 at_last;

   assign at_last = fan_ff == LAST_FAN;

   always_comb begin
      state_in = state_ff;
      fan_in   = fan_ff;
      run_in   = run_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               unique case (stat.action) inside
                  ACT_TICK: begin
                     state_in = ST_CHECK;
                     run_in   = 1'b1;
                  end
                  ACT_READ: begin
                     state_in = ST_LIVE;
                     run_in   = 1'b0;
                     fan_in   = '0;
                  end
                  ACT_EDGE, ACT_CLEAR: ;
               endcase
            end
         end
         ST_CHECK: state_in = stat.due ? ST_DEN : ST_IDLE;
         ST_DEN: begin
            state_in = ST_FAN;
            fan_in   = '0;
         end
         ST_FAN: begin
            if (!stat.timed_out) begin
               state_in = ST_DIV;
            end else if (at_last) begin
               state_in = ST_LIVE;
               fan_in   = '0;
            end else begin
               fan_in = fan_ff + FAN_IDX_W'(1);
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               if (at_last) begin
                  state_in = ST_LIVE;
                  fan_in   = '0;
               end else begin
                  state_in = ST_FAN;
                  fan_in   = fan_ff + FAN_IDX_W'(1);
               end
            end
         end
         ST_LIVE: begin
            if (at_last) begin
               state_in = ST_LOAD;
               fan_in   = '0;
            end else begin
               fan_in = fan_ff + FAN_IDX_W'(1);
            end
         end
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (stat.rsp_taken) begin
               if (run_ff && !at_last) begin
                  state_in = ST_LOAD;
                  fan_in   = fan_ff + FAN_IDX_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl          = '0;
      ctrl.fan      = fan_ff;
      ctrl.run      = run_ff;
      ctrl.last_fan = at_last;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.tick      = stat.req_valid && stat.action == ACT_TICK;
            ctrl.pulse     = stat.req_valid && stat.action == ACT_EDGE;
            ctrl.clear     = stat.req_valid && stat.action == ACT_CLEAR;
         end
         ST_CHECK: ;
         ST_DEN:  ctrl.den_load = 1'b1;
         ST_FAN: begin
            ctrl.fan_zero  = stat.timed_out;
            ctrl.div_start = !stat.timed_out;
         end
         ST_DIV:  ctrl.div_store = stat.div_done;
         ST_LIVE: ctrl.live_calc = 1'b1;
         ST_LOAD: ctrl.out_load  = 1'b1;
         ST_SEND: ctrl.rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fan_ff   <= '0;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fan_ff   <= fan_in;
         run_ff   <= run_in;
      end
   end

endmodule

FILE: rtl/core/multi_fan_tachometer_top.sv
// Multi-fan tachometer: pulse counting, periodic rpm measurement and status reads.
//
// req_ch carries one item per event: a millisecond tick, a falling tach edge,
// a fan clear or a fan read, with the addressed fan index. csr_ch writes the
// measurement interval, timeout, pulses per revolution and minimum rpm; it is
// always ready. rsp_ch returns results from a measurement run (one per fan,
// in fan order, last on the final one) or one reply per read.
// Edges and clears are taken in the idle state; a tick that starts no run
// passes through the check state back to idle. A tick that starts a run
// loads the denominator, then per fan zeroes a timed-out fan or computes its
// rpm through the shared divider (stopping early when the quotient saturates),
// then rebuilds the connection mask fan by fan and loads and sends each result.
// A read rebuilds the connection mask likewise before its reply. req_ch
// stays not ready until the last result of an item is taken; a stalled
// receiver holds the current result. Reset returns the registers to their
// defaults and clears time, counts, stamps and rpm values in the same cycle.
`timescale 1ns / 1ps

module multi_fan_tachometer_top import mft_pkg::*; #(
   parameter int FAN_COUNT = FAN_COUNT_DEF
) (
   input  logic  clock,
   input  logic  reset,
   mft_req_if.sink   req_ch,
   mft_rsp_if.source rsp_ch,
   mft_csr_if.sink   csr_ch
);

   localparam int FIDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
   localparam logic [FAN_IDX_W:0] FAN_LIMIT = (FAN_IDX_W + 1)'(FAN_COUNT);

   mft_ctrl_type ctrl;
   mft_stat_type stat;

   logic [15:0]      interval_ff, timeout_ff, min_rpm_ff;
   logic [PPR_W-1:0] ppr_ff;

   logic [TIME_W-1:0]  time_ff, last_ff;
   logic [COUNT_W-1:0] count_ff [FAN_COUNT];
   logic [TIME_W-1:0]  stamp_ff [FAN_COUNT];
   logic [RPM_W-1:0]   rpm_ff   [FAN_COUNT];
   logic [FAN_COUNT-1:0] live_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [FAN_IDX_W-1:0] sel_ff;

   logic                 out_update_ff, out_conn_ff, out_stall_ff, out_last_ff;
   logic [FAN_IDX_W-1:0] out_fan_ff;
   logic [RPM_W-1:0]     out_rpm_ff;
   logic [MASK_W-1:0]    out_mask_ff;

   logic [FIDX_W-1:0]  cur;
   logic [TIME_W-1:0]  age, elapsed, elapsed_nz;
   logic [PPR_W-1:0]   ppr_nz;
   logic [NUM_W-1:0]   num;
   logic               div_done;
   logic [RPM_W-1:0]   quot;
   logic               req_in_range;
   logic               live_now;
   logic [FAN_IDX_W-1:0] out_idx;
   logic               out_in_range;
   logic [RPM_W-1:0]   out_rpm;
   logic               out_conn;
   logic [MASK_W-1:0]  mask;

   mft_seq #(.FAN_COUNT(FAN_COUNT)) u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   mft_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign cur          = ctrl.fan[FIDX_W-1:0];
   assign age          = time_ff - stamp_ff[cur];
   assign elapsed      = time_ff - last_ff;
   assign elapsed_nz   = (elapsed == '0) ? TIME_W'(1) : elapsed;
   assign ppr_nz       = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign num          = NUM_W'(count_ff[cur]) * NUM_W'(RPM_SCALE);
   assign live_now     = (age < TIME_W'(timeout_ff)) && (rpm_ff[cur] != '0);
   assign req_in_range = {1'b0, req_ch.fan_addr} < FAN_LIMIT;

   assign stat.req_valid = req_ch.valid;
   assign stat.action    = mft_action_type'(req_ch.action);
   assign stat.due       = elapsed >= TIME_W'(interval_ff);
   assign stat.timed_out = age > TIME_W'(timeout_ff);
   assign stat.div_done  = div_done;
   assign stat.rsp_taken = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = ctrl.req_ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         timeout_ff  <= TIMEOUT_RESET;
         ppr_ff      <= PPR_RESET;
         min_rpm_ff  <= MIN_RPM_RESET;
      end else if (csr_ch.valid) begin
         unique case (mft_csr_type'(csr_ch.reg_index))
            CSR_INTERVAL: interval_ff <= csr_ch.data;
            CSR_TIMEOUT:  timeout_ff  <= csr_ch.data;
            CSR_PPR:      ppr_ff      <= csr_ch.data[PPR_W-1:0];
            CSR_MIN_RPM:  min_rpm_ff  <= csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         last_ff <= '0;
      end else begin
         if (ctrl.tick) begin
            time_ff <= time_ff + TIME_W'(1);
         end
         if (ctrl.den_load) begin
            last_ff <= time_ff;
         end
      end
      if (ctrl.den_load) begin
         den_ff <= DEN_W'(elapsed_nz) * DEN_W'(ppr_nz);
      end
      if (req_ch.valid && ctrl.req_ready) begin
         sel_ff <= req_ch.fan_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FAN_COUNT; i++) begin
            count_ff[i] <= '0;
            stamp_ff[i] <= '0;
            rpm_ff[i]   <= '0;
         end
         live_ff <= '0;
      end else begin
         for (int i = 0; i < FAN_COUNT; i++) begin
            if (ctrl.pulse && req_in_range && req_ch.fan_addr == FAN_IDX_W'(i)) begin
               count_ff[i] <= count_ff[i] + COUNT_W'(1);
               stamp_ff[i] <= time_ff;
            end
            if (ctrl.clear && req_in_range && req_ch.fan_addr == FAN_IDX_W'(i)) begin
               count_ff[i] <= '0;
               stamp_ff[i] <= '0;
               rpm_ff[i]   <= '0;
            end
            if (ctrl.fan == FAN_IDX_W'(i)) begin
               if (ctrl.fan_zero) begin
                  count_ff[i] <= '0;
                  rpm_ff[i]   <= '0;
               end
               if (ctrl.div_start) begin
                  count_ff[i] <= '0;
               end
               if (ctrl.div_store) begin
                  rpm_ff[i] <= quot;
               end
               if (ctrl.live_calc) begin
                  live_ff[i] <= live_now;
               end
            end
         end
      end
   end

   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < FAN_COUNT) begin : g_on
         assign mask[j] = live_ff[j];
      end else begin : g_off
         assign mask[j] = 1'b0;
      end
   end

   assign out_idx      = ctrl.run ? ctrl.fan : sel_ff;
   assign out_in_range = {1'b0, out_idx} < FAN_LIMIT;
   assign out_rpm      = out_in_range ? rpm_ff[out_idx[FIDX_W-1:0]] : '0;
   assign out_conn     = out_in_range && live_ff[out_idx[FIDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         out_update_ff <= ctrl.run;
         out_fan_ff    <= out_idx;
         out_rpm_ff    <= out_rpm;
         out_conn_ff   <= out_conn;
         out_stall_ff  <= out_conn && (out_rpm < min_rpm_ff);
         out_mask_ff   <= mask;
         out_last_ff   <= !ctrl.run || ctrl.last_fan;
      end
   end

   assign rsp_ch.valid           = ctrl.rsp_valid;
   assign rsp_ch.is_update       = out_update_ff;
   assign rsp_ch.fan_number      = out_fan_ff;
   assign rsp_ch.rpm             = out_rpm_ff;
   assign rsp_ch.connected       = out_conn_ff;
   assign rsp_ch.stalled         = out_stall_ff;
   assign rsp_ch.connection_mask = out_mask_ff;
   assign rsp_ch.last            = out_last_ff;

endmodule

FILE: tb/tb_multi_fan_tachometer_top.sv
// Self-checking testbench for the multi-fan tachometer: directed and random events.
`timescale 1ns / 1ps

module tb_multi_fan_tachometer_top;
   import mft_pkg::*;

   localparam int NFANS = FAN_COUNT_DEF;

   typedef struct packed {
      logic              is_update;
      logic [2:0]        fan_number;
      logic [RPM_W-1:0]  rpm;
      logic              connected;
      logic              stalled;
      logic [MASK_W-1:0] connection_mask;
      logic              last;
   } fan_report_type;

   logic clock = 1'b0;
   logic reset;

   mft_req_if req_ch();
   mft_rsp_if rsp_ch();
   mft_csr_if csr_ch();

   multi_fan_tachometer_top #(.FAN_COUNT(NFANS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   logic [TIME_W-1:0]  tach_time;
   logic [TIME_W-1:0]  tach_last_run;
   logic [COUNT_W-1:0] tach_pulses [NFANS];
   logic [TIME_W-1:0]  tach_stamp  [NFANS];
   logic [RPM_W-1:0]   tach_rpm    [NFANS];
   logic [15:0]        set_interval;
   logic [15:0]        set_timeout;
   logic [PPR_W-1:0]   set_ppr;
   logic [15:0]        set_min_rpm;

   fan_report_type expected_reports[$];
   int  mismatches;
   int  items_sent;
   int  runs_predicted;
   int  reads_predicted;
   int  reg_writes;
   int  settings_used;
   bit  no_idle;

   function automatic logic fan_alive(int f);
      logic [TIME_W-1:0] age;
      age = tach_time - tach_stamp[f];
      return (age < set_timeout) && (tach_rpm[f] != '0);
   endfunction

   function automatic logic [MASK_W-1:0] alive_mask();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < NFANS && i < MASK_W; i++) begin
         if (fan_alive(i)) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic fan_report_type make_report(logic upd, logic [2:0] f,
                                                  logic [MASK_W-1:0] mask, logic last);
      fan_report_type r;
      logic           alive;
      r = '0;
      alive = 1'b0;
      if (f < NFANS) begin
         alive = fan_alive(f);
         r.rpm = tach_rpm[f];
      end
      r.is_update = upd;
      r.fan_number = f;
      r.connected = alive;
      r.stalled = alive && (r.rpm < set_min_rpm);
      r.connection_mask = mask;
      r.last = last;
      return r;
   endfunction

   task automatic predict_event(mft_action_type act, logic [2:0] f);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] age;
      logic [63:0]       den;
      logic [63:0]       quo;
      logic [MASK_W-1:0] mask;
      case (act)
         ACT_TICK: begin
            tach_time = tach_time + 1;
            elapsed = tach_time - tach_last_run;
            if (elapsed >= set_interval) begin
               den = (elapsed == '0) ? 64'd1 : 64'(elapsed);
               den = den * ((set_ppr == '0) ? 64'd1 : 64'(set_ppr));
               for (int i = 0; i < NFANS; i++) begin
                  age = tach_time - tach_stamp[i];
                  if (age > set_timeout) begin
                     tach_rpm[i] = '0;
                  end else begin
                     quo = (64'(tach_pulses[i]) * 64'd60000) / den;
                     tach_rpm[i] = (quo > 64'd65535) ? RPM_MAX : quo[RPM_W-1:0];
                  end
                  tach_pulses[i] = '0;
               end
               mask = alive_mask();
               for (int i = 0; i < NFANS; i++) begin
                  expected_reports.push_back(make_report(1'b1, 3'(i), mask, i == NFANS - 1));
               end
               tach_last_run = tach_time;
               runs_predicted++;
            end
         end
         ACT_EDGE: begin
            if (f < NFANS) begin
               tach_pulses[f] = tach_pulses[f] + 1;
               tach_stamp[f] = tach_time;
            end
         end
         ACT_CLEAR: begin
            if (f < NFANS) begin
               tach_pulses[f] = '0;
               tach_stamp[f] = '0;
               tach_rpm[f] = '0;
            end
         end
         default: begin
            expected_reports.push_back(make_report(1'b0, f, alive_mask(), 1'b1));
            reads_predicted++;
         end
      endcase
   endtask

   task automatic send_event(mft_action_type act, logic [2:0] f);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.fan_addr <= f;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_event(act, f);
      items_sent++;
   endtask

   task automatic drain_block();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
   endtask

   task automatic write_register(mft_csr_type idx, logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_INTERVAL: set_interval = val;
         CSR_TIMEOUT:  set_timeout = val;
         CSR_PPR:      set_ppr = val[PPR_W-1:0];
         default:      set_min_rpm = val;
      endcase
      reg_writes++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure(logic [15:0] interval, logic [15:0] timeout,
                              logic [15:0] ppr, logic [15:0] min_rpm);
      drain_block();
      write_register(CSR_INTERVAL, interval);
      write_register(CSR_TIMEOUT, timeout);
      write_register(CSR_PPR, ppr);
      write_register(CSR_MIN_RPM, min_rpm);
      settings_used++;
   endtask

   task automatic test_reset_reads();
      send_event(ACT_READ, 3'd0);
      send_event(ACT_READ, 3'd5);
      send_event(ACT_READ, 3'd6);
      send_event(ACT_READ, 3'd7);
   endtask

   task automatic test_measure_run();
      reconfigure(16'd3, 16'd5, 16'd1, 16'd0);
      send_event(ACT_EDGE, 3'd0);
      send_event(ACT_EDGE, 3'd0);
      send_event(ACT_EDGE, 3'd5);
      send_event(ACT_EDGE, 3'd7);
      send_event(ACT_CLEAR, 3'd5);
      repeat (3) send_event(ACT_TICK, 3'd0);
      send_event(ACT_READ, 3'd0);
   endtask

   task automatic test_timeout_boundary();
      // zero interval and zero pulses per rev; age equal to, then past, the timeout
      reconfigure(16'd0, 16'd1, 16'd0, 16'd65535);
      send_event(ACT_EDGE, 3'd1);
      send_event(ACT_TICK, 3'd0);
      send_event(ACT_TICK, 3'd0);
      send_event(ACT_READ, 3'd1);
   endtask

   task automatic test_rpm_saturation();
      reconfigure(16'd1, 16'd65535, 16'd1, 16'd65535);
      repeat (3) send_event(ACT_EDGE, 3'd2);
      send_event(ACT_EDGE, 3'd3);
      send_event(ACT_TICK, 3'd0);
      send_event(ACT_READ, 3'd3);
   endtask

   task automatic test_register_extremes();
      reconfigure(16'd65535, 16'd65535, 16'd15, 16'd0);
      send_event(ACT_EDGE, 3'd0);
      send_event(ACT_TICK, 3'd0);
      send_event(ACT_READ, 3'd6);
   endtask

   task automatic test_random_traffic();
      int          pick;
      logic [15:0] interval;
      logic [15:0] timeout;
      logic [15:0] min_rpm;
      logic [2:0]  fan;
      for (int phase = 0; phase < 8; phase++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)      interval = 16'd0;
         else if (pick < 20) interval = 16'd1;
         else if (pick < 95) interval = 16'($urandom_range(2, 16));
         else                interval = 16'($urandom_range(17, 40));
         pick = $urandom_range(0, 99);
         if (pick < 15)      timeout = 16'd65535;
         else if (pick < 25) timeout = 16'd1;
         else                timeout = 16'($urandom_range(2, 40));
         pick = $urandom_range(0, 3);
         case (pick)
            0:       min_rpm = 16'd0;
            1:       min_rpm = 16'd65535;
            2:       min_rpm = 16'($urandom_range(0, 65535));
            default: min_rpm = 16'($urandom_range(1000, 30000));
         endcase
         reconfigure(interval, timeout, 16'($urandom_range(0, 15)), min_rpm);
         no_idle = (phase % 4 == 3);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 88) fan = 3'($urandom_range(0, NFANS - 1));
            else                            fan = 3'($urandom_range(NFANS, 7));
            pick = $urandom_range(0, 99);
            if (pick < 42)      send_event(ACT_TICK, fan);
            else if (pick < 82) send_event(ACT_EDGE, fan);
            else if (pick < 87) send_event(ACT_CLEAR, fan);
            else                send_event(ACT_READ, fan);
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic note_mismatch(string what, fan_report_type want, fan_report_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH %s", what);
         $display("   expected upd=%0d fan=%0d rpm=%0d conn=%0d stall=%0d mask=%b last=%0d",
                  want.is_update, want.fan_number, want.rpm, want.connected,
                  want.stalled, want.connection_mask, want.last);
         $display("   actual   upd=%0d fan=%0d rpm=%0d conn=%0d stall=%0d mask=%b last=%0d",
                  got.is_update, got.fan_number, got.rpm, got.connected,
                  got.stalled, got.connection_mask, got.last);
      end
   endtask

   always @(posedge clock) begin : check_reports
      fan_report_type got;
      fan_report_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.is_update = rsp_ch.is_update;
         got.fan_number = rsp_ch.fan_number;
         got.rpm = rsp_ch.rpm;
         got.connected = rsp_ch.connected;
         got.stalled = rsp_ch.stalled;
         got.connection_mask = rsp_ch.connection_mask;
         got.last = rsp_ch.last;
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               note_mismatch("wrong field", want, got);
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_TICK;
      req_ch.fan_addr <= 3'd0;
      csr_ch.valid <= 1'b0;
      csr_ch.reg_index <= CSR_INTERVAL;
      csr_ch.data <= 16'd0;
      tach_time = '0;
      tach_last_run = '0;
      for (int i = 0; i < NFANS; i++) begin
         tach_pulses[i] = '0;
         tach_stamp[i] = '0;
         tach_rpm[i] = '0;
      end
      set_interval = INTERVAL_RESET;
      set_timeout = TIMEOUT_RESET;
      set_ppr = PPR_RESET;
      set_min_rpm = MIN_RPM_RESET;
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_reads();
      test_measure_run();
      test_timeout_boundary();
      test_rpm_saturation();
      test_register_extremes();
      test_random_traffic();
      drain_block();

      if (expected_reports.size() != 0) begin
         $display("%0d expected results never arrived", expected_reports.size());
         mismatches += expected_reports.size();
      end
      $display("Sent %0d items under %0d register settings (%0d register writes).",
               items_sent, settings_used, reg_writes);
      $display("Predicted %0d measurement runs and %0d read replies; %0d mismatches.",
               runs_predicted, reads_predicted, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
